// ----- hdl/mefn_pkg.sv -----
// Shared constants and controller/datapath types for edge and facet numbering.
`timescale 1ns / 1ps
package mefn_pkg;

  localparam int VertexBits    = 16;
  localparam int EdgeCapacity  = 4096;
  localparam int FacetCapacity = 4096;

  localparam int EdgeAw   = $clog2(EdgeCapacity);
  localparam int FacetAw  = $clog2(FacetCapacity);
  localparam int PtrW     = (EdgeAw > FacetAw) ? EdgeAw : FacetAw;
  localparam int CntW     = PtrW + 1;
  localparam int EdgeKeyW = 2 * VertexBits;
  localparam int FacetKeyW = 3 * VertexBits;

  localparam int VtxW   = 16;
  localparam int SlotW  = 3;
  localparam int IndexW = 12;
  localparam int StepW  = 4;

  localparam logic [StepW-1:0] NumEdges  = StepW'(6);
  localparam logic [StepW-1:0] LastStep  = StepW'(9);

  // Controller to datapath
  typedef struct packed {
    logic load;   // latch a tetrahedron, restart at the first edge
    logic start;  // latch the sorted key, rewind the scan pointer
    logic adv;    // advance the scan pointer
    logic hit;    // load a found result
    logic miss;   // insert the key or flag the table full
    logic next;   // move to the next edge or facet
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic match;
    logic ptr_last;
    logic step_last;
  } stat_t;

endpackage

// ----- hdl/mefn_tet_if.sv -----
// Tetrahedron input channel: four vertex numbers with valid/ready.
`timescale 1ns / 1ps
interface mefn_tet_if;
  import mefn_pkg::*;
  logic            valid;
  logic            ready;
  logic [VtxW-1:0] vertex_a;
  logic [VtxW-1:0] vertex_b;
  logic [VtxW-1:0] vertex_c;
  logic [VtxW-1:0] vertex_d;

  modport source (output valid, vertex_a, vertex_b, vertex_c, vertex_d, input ready);
  modport sink   (input valid, vertex_a, vertex_b, vertex_c, vertex_d, output ready);
endinterface

// ----- hdl/mefn_res_if.sv -----
// Result channel: one edge or facet number per transfer with valid/ready.
`timescale 1ns / 1ps
interface mefn_res_if;
  import mefn_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SlotW-1:0]  slot;
  logic [IndexW-1:0] entry_index;
  logic              is_new;
  logic              table_full;
  logic              last;

  modport source (output valid, kind, slot, entry_index, is_new, table_full, last,
                  input ready);
  modport sink   (input valid, kind, slot, entry_index, is_new, table_full, last,
                  output ready);
endinterface

// ----- hdl/mefn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mefn_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mefn_datapath.sv -----
// Datapath: vertex hold, key sorting, key tables, counters, scan pointer, result register.
`timescale 1ns / 1ps
module mefn_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mefn_pkg::cmd_t                 cmd_i,
  output mefn_pkg::stat_t                stat_o,
  input  logic [mefn_pkg::VtxW-1:0]      vertex_a_i,
  input  logic [mefn_pkg::VtxW-1:0]      vertex_b_i,
  input  logic [mefn_pkg::VtxW-1:0]      vertex_c_i,
  input  logic [mefn_pkg::VtxW-1:0]      vertex_d_i,
  output logic                           kind_o,
  output logic [mefn_pkg::SlotW-1:0]     slot_o,
  output logic [mefn_pkg::IndexW-1:0]    entry_index_o,
  output logic                           is_new_o,
  output logic                           table_full_o,
  output logic                           last_o
);
  import mefn_pkg::*;

  logic [VertexBits-1:0] vtx_q [4];
  logic [StepW-1:0]      step_q, step_d;
  logic [FacetKeyW-1:0]  key_q, key_d;
  logic [PtrW-1:0]       ptr_q;
  logic [CntW-1:0]       ecnt_q, fcnt_q;
  logic                  facet;
  logic [CntW-1:0]       cnt;
  logic [CntW-1:0]       cap;
  logic [VertexBits-1:0] p0, p1, p2, s0, s1, s2, t0, t1, u0, u1, u2;
  logic [EdgeKeyW-1:0]   erdata;
  logic [FacetKeyW-1:0]  frdata;
  logic                  ewe, fwe;
  logic                  is_full;

  logic                  kind_q;
  logic [SlotW-1:0]      slot_q;
  logic [IndexW-1:0]     index_q;
  logic                  new_q, full_q, last_q;

  assign facet = (step_q >= NumEdges);
  assign cnt   = facet ? fcnt_q : ecnt_q;
  assign cap   = facet ? CntW'(FacetCapacity) : CntW'(EdgeCapacity);
  assign is_full = (cnt >= cap);

  // Pick the vertices of the current edge or facet
  always_comb begin
    p0 = vtx_q[0];
    p1 = vtx_q[1];
    p2 = vtx_q[2];
    case (step_q)
      4'd0: begin p0 = vtx_q[0]; p1 = vtx_q[1]; end
      4'd1: begin p0 = vtx_q[0]; p1 = vtx_q[2]; end
      4'd2: begin p0 = vtx_q[0]; p1 = vtx_q[3]; end
      4'd3: begin p0 = vtx_q[1]; p1 = vtx_q[2]; end
      4'd4: begin p0 = vtx_q[1]; p1 = vtx_q[3]; end
      4'd5: begin p0 = vtx_q[2]; p1 = vtx_q[3]; end
      4'd6: begin p0 = vtx_q[1]; p1 = vtx_q[2]; p2 = vtx_q[3]; end
      4'd7: begin p0 = vtx_q[0]; p1 = vtx_q[2]; p2 = vtx_q[3]; end
      4'd8: begin p0 = vtx_q[0]; p1 = vtx_q[1]; p2 = vtx_q[3]; end
      4'd9: begin p0 = vtx_q[0]; p1 = vtx_q[1]; p2 = vtx_q[2]; end
      default: begin p0 = vtx_q[0]; p1 = vtx_q[1]; p2 = vtx_q[2]; end
    endcase
  end

  // Sort ascending with three compare-exchange steps
  always_comb begin
    s0 = (p0 > p1) ? p1 : p0;
    s1 = (p0 > p1) ? p0 : p1;
    s2 = p2;
    t0 = (s1 > s2) ? s2 : s1;
    t1 = (s1 > s2) ? s1 : s2;
    u0 = (s0 > t0) ? t0 : s0;
    u1 = (s0 > t0) ? s0 : t0;
    u2 = t1;
    if (facet) begin
      key_d = {u0, u1, u2};
    end else begin
      key_d = {{VertexBits{1'b0}}, s0, s1};
    end
  end

  // Key tables
  assign ewe = cmd_i.miss && !facet && !is_full;
  assign fwe = cmd_i.miss && facet && !is_full;

  mefn_ram #(.Width(EdgeKeyW), .Depth(EdgeCapacity)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (ecnt_q[EdgeAw-1:0]),
    .wdata_i (key_q[EdgeKeyW-1:0]),
    .raddr_i (ptr_q[EdgeAw-1:0]),
    .rdata_o (erdata)
  );

  mefn_ram #(.Width(FacetKeyW), .Depth(FacetCapacity)) u_facet_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (fcnt_q[FacetAw-1:0]),
    .wdata_i (key_q),
    .raddr_i (ptr_q[FacetAw-1:0]),
    .rdata_o (frdata)
  );

  // Status for the controller
  assign stat_o.empty     = (cnt == '0);
  assign stat_o.match     = facet ? (frdata == key_q)
                                  : (erdata == key_q[EdgeKeyW-1:0]);
  assign stat_o.ptr_last  = ((CntW'(ptr_q) + CntW'(1)) >= cnt);
  assign stat_o.step_last = (step_q == LastStep);

  always_comb begin
    step_d = step_q;
    if (cmd_i.load) begin
      step_d = '0;
    end else if (cmd_i.next) begin
      step_d = step_q + StepW'(1);
    end
  end

  // Control registers: step, scan pointer, counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      ptr_q  <= '0;
      ecnt_q <= '0;
      fcnt_q <= '0;
    end else begin
      step_q <= step_d;
      if (cmd_i.start) begin
        ptr_q <= '0;
      end else if (cmd_i.adv) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
      if (ewe) begin
        ecnt_q <= ecnt_q + CntW'(1);
      end
      if (fwe) begin
        fcnt_q <= fcnt_q + CntW'(1);
      end
    end
  end

  // Payload registers: vertices, key, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vtx_q[0] <= vertex_a_i[VertexBits-1:0];
      vtx_q[1] <= vertex_b_i[VertexBits-1:0];
      vtx_q[2] <= vertex_c_i[VertexBits-1:0];
      vtx_q[3] <= vertex_d_i[VertexBits-1:0];
    end
    if (cmd_i.start) begin
      key_q <= key_d;
    end
    if (cmd_i.hit || cmd_i.miss) begin
      kind_q <= facet;
      slot_q <= facet ? SlotW'(step_q - NumEdges) : SlotW'(step_q);
      last_q <= (step_q == LastStep);
      if (cmd_i.hit) begin
        index_q <= IndexW'(ptr_q);
        new_q   <= 1'b0;
        full_q  <= 1'b0;
      end else begin
        index_q <= is_full ? '0 : IndexW'(cnt);
        new_q   <= !is_full;
        full_q  <= is_full;
      end
    end
  end

  assign kind_o        = kind_q;
  assign slot_o        = slot_q;
  assign entry_index_o = index_q;
  assign is_new_o      = new_q;
  assign table_full_o  = full_q;
  assign last_o        = last_q;

endmodule

// ----- hdl/mefn_ctrl.sv -----
// Controller: sequences ten table lookups per tetrahedron and the result handshake.
`timescale 1ns / 1ps
module mefn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mefn_pkg::stat_t stat_i,
  output mefn_pkg::cmd_t  cmd_o
);
  import mefn_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SBegin  = 3'd1;
  localparam logic [2:0] SRead   = 3'd2;
  localparam logic [2:0] SCmp    = 3'd3;
  localparam logic [2:0] SResult = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SBegin;
        end
      end
      SBegin: begin
        cmd_o.start = 1'b1;
        state_d     = SRead;
      end
      SRead: begin
        if (stat_i.empty) begin
          cmd_o.miss = 1'b1;
          state_d    = SResult;
        end else begin
          state_d = SCmp;
        end
      end
      SCmp: begin
        if (stat_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = SResult;
        end else if (stat_i.ptr_last) begin
          cmd_o.miss = 1'b1;
          state_d    = SResult;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = SRead;
        end
      end
      SResult: begin
        if (out_ready_i) begin
          if (stat_i.step_last) begin
            state_d = SIdle;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = SBegin;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SResult);

endmodule

// ----- hdl/mesh_edge_facet_numbering_unit.sv -----
// Top level of the mesh edge and facet numbering unit.
// Usage:
//   tet_i carries one tetrahedron (vertex_a..vertex_d) per transfer.
//   res_o returns ten results per tetrahedron, in order: edges (a,b) (a,c)
//   (a,d) (b,c) (b,d) (c,d), then facets (b,c,d) (a,c,d) (a,b,d) (a,b,c);
//   last marks the tenth. Each sorted key gets its insertion-order index;
//   is_new marks a first sighting, table_full an absent key with no room.
// Timing:
//   One tetrahedron at a time; tet_i.ready is high only between items.
//   Each lookup scans its key table linearly through a registered-read RAM,
//   with a read state and a compare state per stored entry; an empty table
//   goes straight from the read state to the result. The result then holds
//   on res_o until taken; an item's cost is set by the table scan loop.
// Reset:
//   Both counts clear; table contents are not cleared and no entry beyond
//   the count is ever read. No clearing pass is needed.
// Stall:
//   A result holds on res_o until taken; the scan waits meanwhile.
`timescale 1ns / 1ps
module mesh_edge_facet_numbering_unit (
  input logic      clk_i,
  input logic      rst_ni,
  mefn_tet_if.sink tet_i,
  mefn_res_if.source res_o
);
  import mefn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mefn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tet_i.valid),
    .in_ready_o  (tet_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mefn_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .vertex_a_i    (tet_i.vertex_a),
    .vertex_b_i    (tet_i.vertex_b),
    .vertex_c_i    (tet_i.vertex_c),
    .vertex_d_i    (tet_i.vertex_d),
    .kind_o        (res_o.kind),
    .slot_o        (res_o.slot),
    .entry_index_o (res_o.entry_index),
    .is_new_o      (res_o.is_new),
    .table_full_o  (res_o.table_full),
    .last_o        (res_o.last)
  );

  // A result is never both a fresh insert and a full-table miss
  a_new_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.is_new && res_o.table_full))
    else $error("result flagged both new and full");

  // Input closes once a tetrahedron is taken
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tet_i.valid && tet_i.ready) |=> !tet_i.ready)
    else $error("input open while an item is in work");

  // Input reopens right after the last result transfer
  a_free_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.last) |=> tet_i.ready)
    else $error("input not reopened after last result");

  // Full-table results carry index zero
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.table_full) |-> (res_o.entry_index == '0))
    else $error("full result with nonzero index");

endmodule

// ----- sim/tb_mesh_edge_facet_numbering_unit.sv -----
// Testbench for the mesh edge and facet numbering unit: random tetrahedra, scoreboard check.
`timescale 1ns / 1ps
module tb_mesh_edge_facet_numbering_unit;
  import mefn_pkg::*;

  typedef struct {
    bit                kind;
    bit [SlotW-1:0]    slot;
    bit [IndexW-1:0]   entry_index;
    bit                is_new;
    bit                table_full;
    bit                last;
  } numbering_t;

  // Tracks the edge and facet tables and the numbers they hand out
  class numbering_board;
    int unsigned       edge_index [bit [EdgeKeyW-1:0]];
    int unsigned       facet_index [bit [FacetKeyW-1:0]];
    int unsigned       edge_count;
    int unsigned       facet_count;
    numbering_t        pending_q[$];
    int                mismatches;

    function automatic void find_edge_key(bit [EdgeKeyW-1:0] key, int k);
      numbering_t r;
      r.kind = 1'b0;
      r.slot = SlotW'(k);
      r.last = 1'b0;
      if (edge_index.exists(key)) begin
        r.entry_index = IndexW'(edge_index[key]);
        r.is_new = 0; r.table_full = 0;
      end else if (edge_count >= EdgeCapacity) begin
        r.entry_index = '0; r.is_new = 0; r.table_full = 1;
      end else begin
        edge_index[key] = edge_count;
        r.entry_index = IndexW'(edge_count);
        r.is_new = 1; r.table_full = 0;
        edge_count++;
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function automatic void find_facet_key(bit [FacetKeyW-1:0] key, int k);
      numbering_t r;
      r.kind = 1'b1;
      r.slot = SlotW'(k);
      r.last = (k == 3);
      if (facet_index.exists(key)) begin
        r.entry_index = IndexW'(facet_index[key]);
        r.is_new = 0; r.table_full = 0;
      end else if (facet_count >= FacetCapacity) begin
        r.entry_index = '0; r.is_new = 0; r.table_full = 1;
      end else begin
        facet_index[key] = facet_count;
        r.entry_index = IndexW'(facet_count);
        r.is_new = 1; r.table_full = 0;
        facet_count++;
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    // Expand one accepted tetrahedron into its ten expected numbers
    function automatic void note_tet(bit [VertexBits-1:0] v[4]);
      int pa[6] = '{0, 0, 0, 1, 1, 2};
      int pb[6] = '{1, 2, 3, 2, 3, 3};
      int fa[4] = '{1, 0, 0, 0};
      int fb[4] = '{2, 2, 1, 1};
      int fc[4] = '{3, 3, 3, 2};
      bit [VertexBits-1:0] x, y, z, t;
      for (int i = 0; i < 6; i++) begin
        x = v[pa[i]]; y = v[pb[i]];
        if (x > y) begin t = x; x = y; y = t; end
        find_edge_key({x, y}, i);
      end
      for (int i = 0; i < 4; i++) begin
        x = v[fa[i]]; y = v[fb[i]]; z = v[fc[i]];
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        find_facet_key({x, y, z}, i);
      end
    endfunction

    task automatic report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task automatic check_result(numbering_t got);
      numbering_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result, slot", got.slot, -1);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind != want.kind) report("kind", got.kind, want.kind);
      if (got.slot != want.slot) report("slot", got.slot, want.slot);
      if (got.entry_index != want.entry_index)
        report("entry_index", got.entry_index, want.entry_index);
      if (got.is_new != want.is_new) report("is_new", got.is_new, want.is_new);
      if (got.table_full != want.table_full)
        report("table_full", got.table_full, want.table_full);
      if (got.last != want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  mefn_tet_if tet_if ();
  mefn_res_if res_if ();

  mesh_edge_facet_numbering_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tet_i (tet_if.sink),
    .res_o (res_if.source)
  );

  numbering_board board = new();
  int unsigned    cycle_count;
  int             hold_off_cycles;

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 20_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall pattern, quiet stretches, one long hold-off on request
  initial begin
    int mode;
    int run;
    res_if.ready = 1'b0;
    mode = 0;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        res_if.ready = 1'b0;
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 2);
          run = $urandom_range(20, 300);
        end
        run--;
        case (mode)
          0: res_if.ready = 1'b1;
          1: res_if.ready = ($urandom_range(0, 3) != 0);
          default: res_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    numbering_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind = res_if.kind;
      got.slot = res_if.slot;
      got.entry_index = res_if.entry_index;
      got.is_new = res_if.is_new;
      got.table_full = res_if.table_full;
      got.last = res_if.last;
      board.check_result(got);
    end
  end

  // Offer one tetrahedron and hold it until the transfer
  task automatic send_tet(bit [VtxW-1:0] a, bit [VtxW-1:0] b, bit [VtxW-1:0] c,
                          bit [VtxW-1:0] d);
    bit [VertexBits-1:0] v[4];
    tet_if.valid = 1'b1;
    tet_if.vertex_a = a;
    tet_if.vertex_b = b;
    tet_if.vertex_c = c;
    tet_if.vertex_d = d;
    do @(posedge clk_i); while (!tet_if.ready);
    v = '{a, b, c, d};
    board.note_tet(v);
    @(negedge clk_i);
  endtask

  task automatic idle_tet(int cycles);
    tet_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Vertex numbers drawn mostly from a small pool keep the tables short
  function automatic bit [VtxW-1:0] pick_vertex();
    bit [VtxW-1:0] pool[9] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
                               16'h5555, 16'hAAAA, 16'hFFFF, 16'h8000};
    if ($urandom_range(0, 99) < 6) return VtxW'($urandom);
    return pool[$urandom_range(0, 8)];
  endfunction

  initial begin
    int burst;
    rst_ni = 1'b0;
    tet_if.valid = 1'b0;
    tet_if.vertex_a = '0;
    tet_if.vertex_b = '0;
    tet_if.vertex_c = '0;
    tet_if.vertex_d = '0;
    hold_off_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, repeated vertices, wide numbers, repeats of known keys
    send_tet(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tet(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tet(16'h0000, 16'h0001, 16'h0002, 16'h0003);
    send_tet(16'h0003, 16'h0002, 16'h0001, 16'h0000);
    send_tet(16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555);
    send_tet(16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF);
    send_tet(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_tet(16'h0001, 16'h0001, 16'h0002, 16'h0002);
    send_tet(16'h0004, 16'h0003, 16'h0003, 16'h0003);
    idle_tet(5);
    send_tet(16'h0002, 16'h0000, 16'h0003, 16'h0001);
    send_tet(16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0);
    send_tet(16'hF0F0, 16'h0F0F, 16'hFEDC, 16'h1234);

    // Random bursts with gaps; pressure events partway through
    for (int n = 0; n < 180; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        if (n + k == 40) hold_off_cycles = 3000;
        send_tet(pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex());
      end
      if (n > 100 && n < 115) begin
        tet_if.valid = 1'b0;
        while (board.pending_q.size() != 0) @(negedge clk_i);
      end
      idle_tet($urandom_range(0, 1) ? 0 : $urandom_range(1, 60));
    end
    tet_if.valid = 1'b0;

    // Drain, then let the block settle
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
